### rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned CNT_BITS  = $clog2(WORD_BITS + 1);

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]                  mode;
        logic signed [WORD_BITS-1:0] a_num;
        logic signed [WORD_BITS-1:0] a_den;
        logic signed [WORD_BITS-1:0] b_num;
        logic signed [WORD_BITS-1:0] b_den;
    } t_rau_in;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] res_num;
        logic [WORD_BITS-2:0]        res_den;
        logic                        zero_den;
        logic                        overflow;
    } t_rau_out;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### rtl/rau_divu.sv
// Unsigned restoring divider, one quotient bit per cycle.
module rau_divu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rau_pkg::WORD_BITS-1:0] i_dividend,
    input  logic [rau_pkg::WORD_BITS-1:0] i_divisor,
    output rau_pkg::t_div_stat            o_stat,
    output logic [rau_pkg::WORD_BITS-1:0] o_quo,
    output logic [rau_pkg::WORD_BITS-1:0] o_rem
);
    import rau_pkg::*;

    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [WORD_BITS-1:0] r_rem, n_rem;
    logic [WORD_BITS-1:0] r_quo, n_quo;
    logic [WORD_BITS-1:0] r_dvs, n_dvs;
    logic [WORD_BITS:0]   shifted;
    logic [WORD_BITS:0]   diff;

    // Trial subtract of the divisor from the shifted partial remainder
    assign shifted = {r_rem, r_quo[WORD_BITS-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_cnt  = CNT_BITS'(WORD_BITS);
            n_busy = 1'b1;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = diff[WORD_BITS] ? shifted[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
            n_quo = {r_quo[WORD_BITS-2:0], ~diff[WORD_BITS]};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule

### rtl/rational_arith_unit.sv
// Top level of the rational arithmetic unit: sequencer, multiplier and divider.
// One request at a time: two or three 32x32 products, then a Euclid GCD that
// runs one division per remainder step on the shared divider, then two more
// divisions that reduce numerator and denominator. The input is ready only
// while the unit is idle, and a result stays offered until it is taken.
module rational_arith_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  rau_pkg::t_rau_in  i_req,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output rau_pkg::t_rau_out o_res
);
    import rau_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_MST   = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_GCHK  = 4'd4;
    localparam logic [3:0] S_GWAIT = 4'd5;
    localparam logic [3:0] S_NST   = 4'd6;
    localparam logic [3:0] S_NWAIT = 4'd7;
    localparam logic [3:0] S_DST   = 4'd8;
    localparam logic [3:0] S_DWAIT = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    localparam logic [WORD_BITS-1:0] MIN_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};

    logic [3:0]                    r_state, n_state;
    logic [1:0]                    r_step, n_step;
    t_rau_in                       r_req;
    logic signed [2*WORD_BITS-1:0] r_prod;
    logic [WORD_BITS-1:0]          r_p, r_q, r_n, r_d;
    logic [WORD_BITS-1:0]          r_ga, r_gb;
    logic                          r_ovf, r_zden;
    t_rau_out                      r_res;

    logic signed [WORD_BITS-1:0]   mul_a, mul_b;
    logic signed [2*WORD_BITS-1:0] prod;
    logic                          prod_ovf;
    logic [WORD_BITS:0]            sum;
    logic [WORD_BITS-1:0]          mag_n, mag_d;
    logic                          div_start;
    logic [WORD_BITS-1:0]          div_a, div_b, div_quo, div_rem;
    t_div_stat                     div_stat;

    // Select multiplier operands by mode and step
    always_comb begin
        mul_a = r_req.a_den;
        mul_b = r_req.b_den;
        case (r_step)
            2'd0: begin
                mul_a = r_req.a_num;
                mul_b = (r_req.mode == MODE_MUL) ? r_req.b_num : r_req.b_den;
            end
            2'd1: begin
                mul_a = r_req.b_num;
                mul_b = r_req.a_den;
            end
            default: begin
                mul_a = r_req.a_den;
                mul_b = (r_req.mode == MODE_DIV) ? r_req.b_num : r_req.b_den;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ovf = !((&r_prod[2*WORD_BITS-1:WORD_BITS-1]) ||
                        !(|r_prod[2*WORD_BITS-1:WORD_BITS-1]));
    assign sum      = (r_req.mode == MODE_SUB)
                    ? {r_p[WORD_BITS-1], r_p} - {r_q[WORD_BITS-1], r_q}
                    : {r_p[WORD_BITS-1], r_p} + {r_q[WORD_BITS-1], r_q};
    assign mag_n    = r_n[WORD_BITS-1] ? (~r_n + 1'b1) : r_n;
    assign mag_d    = r_d[WORD_BITS-1] ? (~r_d + 1'b1) : r_d;

    // Feed the shared divider
    always_comb begin
        div_start = 1'b0;
        div_a     = mag_n;
        div_b     = r_ga;
        unique case (r_state)
            S_GCHK: begin
                div_start = (r_gb != '0);
                div_a     = r_ga;
                div_b     = r_gb;
            end
            S_NST:   div_start = 1'b1;
            S_DST: begin
                div_start = 1'b1;
                div_a     = mag_d;
            end
            default: div_start = 1'b0;
        endcase
    end

    rau_divu u_divu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_stat     (div_stat),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE:  if (i_req_valid) begin
                n_state = S_MUL;
                n_step  = (i_req.mode == MODE_ADD || i_req.mode == MODE_SUB)
                        ? 2'd0 : 2'd2;
            end
            S_MUL:   n_state = S_MST;
            S_MST: begin
                if (r_step == 2'd2) begin
                    n_state = (r_req.mode == MODE_ADD || r_req.mode == MODE_SUB)
                            ? S_SUM : S_GCHK;
                    if (r_req.mode == MODE_MUL || r_req.mode == MODE_DIV) begin
                        n_step  = 2'd0;
                        n_state = S_MUL;
                    end
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = S_MUL;
                end
                if (r_step == 2'd0 && r_req.mode != MODE_ADD && r_req.mode != MODE_SUB)
                    n_state = S_SUM;
            end
            S_SUM:   n_state = S_GCHK;
            S_GCHK:  n_state = (r_gb == '0) ? S_NST : S_GWAIT;
            S_GWAIT: if (div_stat.done) n_state = S_GCHK;
            S_NST:   n_state = S_NWAIT;
            S_NWAIT: if (div_stat.done) n_state = S_DST;
            S_DST:   n_state = S_DWAIT;
            S_DWAIT: if (div_stat.done) n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (i_res_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) begin
            r_req <= i_req;
            r_ovf <= 1'b0;
            r_zden <= 1'b0;
        end
        if (r_state == S_MUL)
            r_prod <= prod;
        // Store the wrapped product: step 0 into p and n, 1 into q, 2 into d
        if (r_state == S_MST) begin
            if (prod_ovf)
                r_ovf <= 1'b1;
            case (r_step)
                2'd0: begin
                    r_p <= r_prod[WORD_BITS-1:0];
                    r_n <= r_prod[WORD_BITS-1:0];
                end
                2'd1:    r_q <= r_prod[WORD_BITS-1:0];
                default: r_d <= r_prod[WORD_BITS-1:0];
            endcase
        end
        if (r_state == S_SUM) begin
            if (r_req.mode == MODE_ADD || r_req.mode == MODE_SUB) begin
                r_n <= sum[WORD_BITS-1:0];
                if (sum[WORD_BITS] != sum[WORD_BITS-1])
                    r_ovf <= 1'b1;
                if (mag_d == '0 || sum[WORD_BITS-1:0] == '0) begin
                    r_ga <= WORD_BITS'(1);
                    r_gb <= '0;
                end else begin
                    r_ga <= mag_d;
                    r_gb <= sum[WORD_BITS-1] ? (~sum[WORD_BITS-1:0] + 1'b1)
                                             : sum[WORD_BITS-1:0];
                end
            end else if (mag_d == '0 || mag_n == '0) begin
                r_ga <= WORD_BITS'(1);
                r_gb <= '0;
            end else begin
                r_ga <= mag_d;
                r_gb <= mag_n;
            end
        end
        // Advance Euclid by one remainder
        if (r_state == S_GWAIT && div_stat.done) begin
            r_ga <= r_gb;
            r_gb <= div_rem;
        end
        if (r_state == S_NWAIT && div_stat.done)
            r_n <= r_n[WORD_BITS-1] ? (~div_quo + 1'b1) : div_quo;
        if (r_state == S_DWAIT && div_stat.done)
            r_d <= r_d[WORD_BITS-1] ? (~div_quo + 1'b1) : div_quo;
        // Normalize the sign and a zero denominator
        if (r_state == S_FIN) begin
            r_res.zero_den <= (r_d == '0);
            if (r_d[WORD_BITS-1]) begin
                r_res.res_num  <= ~r_n + 1'b1;
                r_res.res_den  <= (r_d == MIN_NEG) ? MAX_POS[WORD_BITS-2:0]
                                                   : mag_d[WORD_BITS-2:0];
                r_res.overflow <= r_ovf || (r_d == MIN_NEG) || (r_n == MIN_NEG);
            end else begin
                r_res.res_num  <= r_n;
                r_res.res_den  <= (r_d == '0) ? (WORD_BITS-1)'(1)
                                              : r_d[WORD_BITS-2:0];
                r_res.overflow <= r_ovf;
            end
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;

endmodule

### rtl/rau_checker.sv
// Port-level checks for the rational arithmetic unit, bound to the top level.
module rau_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              o_req_ready,
    input logic              o_res_valid,
    input logic              i_res_ready,
    input rau_pkg::t_rau_out o_res
);
    import rau_pkg::*;

    // Hold a stalled result
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("result changed while stalled");

    // Never offer a zero denominator
    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_res.res_den != '0)
        else $error("zero denominator delivered");

    // Take no request while a result is pending
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_req_ready && o_res_valid))
        else $error("ready while result pending");

    // Drop ready after a request is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready && !o_res_valid)
        else $error("not busy after request");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_res       (o_res)
);

### test/tb_rational_arith_unit.sv
// Testbench for the rational arithmetic unit: directed table plus random requests.
module tb_rational_arith_unit;
    import rau_pkg::*;

    localparam int NUM_RANDOM = 400;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_req_valid = 1'b0;
    logic     o_req_ready;
    t_rau_in  i_req = '0;
    logic     o_res_valid;
    logic     i_res_ready = 1'b0;
    t_rau_out o_res;

    // Fractions waiting to come out of the unit
    t_rau_out expected_fracs[$];
    int       error_count = 0;
    int       send_idle_pct = 23;
    int       recv_idle_pct = 83;
    bit       recv_hold = 1'b0;
    bit       stim_done = 1'b0;

    // Directed requests; known answers only where obvious
    typedef struct {
        t_rau_in  req;
        bit       has_known;
        t_rau_out known;
    } t_dir_row;

    t_dir_row dir_rows[$];

    rational_arith_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    always #5 i_clk = ~i_clk;

    // Limit the run time
    initial begin
        #100000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint sext32(input logic [31:0] x);
        sext32 = longint'($signed(x));
    endfunction

    // Wrap to 32 bits and note overflow
    function automatic longint wrap32(input longint x, inout bit ovf);
        longint w;
        w = sext32(x[31:0]);
        if (w != x) ovf = 1'b1;
        wrap32 = w;
    endfunction

    function automatic longint unsigned euclid_gcd(input longint unsigned p,
                                                   input longint unsigned q);
        longint unsigned r;
        if (p == 0 || q == 0) return 1;
        while (q != 0) begin
            r = p % q;
            p = q;
            q = r;
        end
        euclid_gcd = p;
    endfunction

    // Compute the reduced fraction for one request
    function automatic t_rau_out reduce_fraction(input t_rau_in rq);
        longint an, ad, bn, bd, n, d, p, q, wmax;
        longint unsigned g;
        bit ovf, zden;
        t_rau_out r;
        an = sext32(rq.a_num);
        ad = sext32(rq.a_den);
        bn = sext32(rq.b_num);
        bd = sext32(rq.b_den);
        ovf = 1'b0;
        zden = 1'b0;
        wmax = 64'sd2147483647;
        case (rq.mode) inside
            MODE_ADD, MODE_SUB: begin
                p = wrap32(an * bd, ovf);
                q = wrap32(bn * ad, ovf);
                n = wrap32(rq.mode == MODE_ADD ? p + q : p - q, ovf);
                d = wrap32(ad * bd, ovf);
            end
            MODE_MUL: begin
                n = wrap32(an * bn, ovf);
                d = wrap32(ad * bd, ovf);
            end
            default: begin
                n = wrap32(an * bd, ovf);
                d = wrap32(ad * bn, ovf);
            end
        endcase
        g = euclid_gcd(d < 0 ? -d : d, n < 0 ? -n : n);
        n = n / longint'(g);
        d = d / longint'(g);
        if (d == 0) begin
            d = 1;
            zden = 1'b1;
        end
        if (d < 0) begin
            d = -d;
            if (d > wmax) begin
                d = wmax;
                ovf = 1'b1;
            end
            n = wrap32(-n, ovf);
        end
        r.res_num = n[31:0];
        r.res_den = d[30:0];
        r.zero_den = zden;
        r.overflow = ovf;
        reduce_fraction = r;
    endfunction

    function automatic t_rau_out mk_frac(input logic [31:0] n, input logic [30:0] d,
                                         input bit z, input bit o);
        t_rau_out r;
        r.res_num = n;
        r.res_den = d;
        r.zero_den = z;
        r.overflow = o;
        mk_frac = r;
    endfunction

    function automatic t_rau_in mk_req(input logic [1:0] m, input logic [31:0] an,
                                       input logic [31:0] ad, input logic [31:0] bn,
                                       input logic [31:0] bd);
        t_rau_in r;
        r.mode = m;
        r.a_num = an;
        r.a_den = ad;
        r.b_num = bn;
        r.b_den = bd;
        mk_req = r;
    endfunction

    task automatic add_row(input t_rau_in rq, input bit known_ok, input t_rau_out k);
        t_dir_row row;
        row.req = rq;
        row.has_known = known_ok;
        row.known = k;
        dir_rows.push_back(row);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: rand_word = $urandom_range(0, 12) - 6;
            1: rand_word = $urandom_range(0, 1000);
            2: rand_word = -$urandom_range(1, 1000);
            3: rand_word = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: rand_word = $urandom;
        endcase
    endfunction

    // Offer one request and hold it until accepted; called at a falling edge
    task automatic send_request(input t_rau_in rq);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req <= rq;
        i_req_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        expected_fracs.push_back(reduce_fraction(rq));
        @(negedge i_clk);
    endtask

    // Receiver: randomly stall, long hold when asked
    initial begin
        int hold_cycles;
        forever begin
            @(negedge i_clk);
            if (recv_hold) begin
                i_res_ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < 600; hold_cycles++) @(negedge i_clk);
                recv_hold = 1'b0;
            end
            i_res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_rau_out exp_frac;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (expected_fracs.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_res);
                error_count++;
            end else begin
                exp_frac = expected_fracs.pop_front();
                if (o_res.res_num !== exp_frac.res_num) begin
                    $display("%0t: res_num expected %h actual %h", $time,
                             exp_frac.res_num, o_res.res_num);
                    error_count++;
                end
                if (o_res.res_den !== exp_frac.res_den) begin
                    $display("%0t: res_den expected %h actual %h", $time,
                             exp_frac.res_den, o_res.res_den);
                    error_count++;
                end
                if (o_res.zero_den !== exp_frac.zero_den) begin
                    $display("%0t: zero_den expected %b actual %b", $time,
                             exp_frac.zero_den, o_res.zero_den);
                    error_count++;
                end
                if (o_res.overflow !== exp_frac.overflow) begin
                    $display("%0t: overflow expected %b actual %b", $time,
                             exp_frac.overflow, o_res.overflow);
                    error_count++;
                end
            end
        end
    end

    // Main stimulus
    initial begin
        int k;
        int wait_cycles;
        t_rau_in rq;
        t_rau_out p;

        // Extremes, each operation, and the special cases
        add_row(mk_req(MODE_ADD, 1, 2, 1, 2), 1, mk_frac(1, 1, 0, 0));
        add_row(mk_req(MODE_SUB, 1, 2, 1, 2), 1, mk_frac(0, 4, 0, 0));
        add_row(mk_req(MODE_MUL, 2, 3, 3, 4), 1, mk_frac(1, 2, 0, 0));
        add_row(mk_req(MODE_DIV, 2, 3, 4, 9), 1, mk_frac(3, 2, 0, 0));
        add_row(mk_req(MODE_MUL, 0, 0, 5, 7), 1, mk_frac(0, 1, 1, 0));
        add_row(mk_req(MODE_DIV, 5, 1, 0, 1), 1, mk_frac(5, 1, 1, 0));
        add_row(mk_req(MODE_MUL, 3, -4, 1, 1), 1, mk_frac(-3, 4, 0, 0));
        add_row(mk_req(MODE_MUL, 32'h8000_0000, -1, 1, 1), 1,
                mk_frac(32'h8000_0000, 1, 0, 1));
        add_row(mk_req(MODE_MUL, 1, 32'h8000_0000, 0, 1), 0, '0);
        add_row(mk_req(MODE_MUL, 3, 32'h8000_0000, 1, 1), 1,
                mk_frac(-3, 31'h7fff_ffff, 0, 1));
        add_row(mk_req(MODE_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1), 0, '0);
        add_row(mk_req(MODE_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1), 0, '0);
        add_row(mk_req(MODE_SUB, 32'h8000_0000, 1, 32'h7fff_ffff, 1), 0, '0);
        add_row(mk_req(MODE_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                       32'hffff_ffff), 0, '0);
        add_row(mk_req(MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000), 0, '0);
        add_row(mk_req(MODE_SUB, 0, 0, 0, 0), 1, mk_frac(0, 1, 1, 0));
        add_row(mk_req(MODE_DIV, 32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678,
                       32'hedcb_a987), 0, '0);
        add_row(mk_req(MODE_ADD, 0, 7, 0, 9), 1, mk_frac(0, 63, 0, 0));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].has_known) begin
                p = reduce_fraction(dir_rows[i].req);
                if (p !== dir_rows[i].known) begin
                    $display("%0t: table row %0d expected %h actual %h", $time, i,
                             dir_rows[i].known, p);
                    error_count++;
                end
            end
            send_request(dir_rows[i].req);
        end

        // Random requests in three idling phases
        for (k = 0; k < NUM_RANDOM; k++) begin
            if (k == NUM_RANDOM / 3) begin
                send_idle_pct = 83;
                recv_idle_pct = 23;
            end
            if (k == 2 * NUM_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Long receiver hold while requests keep coming
            if (k == NUM_RANDOM / 2) recv_hold = 1'b1;
            // Pause until the unit has drained
            if (k == NUM_RANDOM / 4) begin
                i_req_valid <= 1'b0;
                wait_cycles = 0;
                while (expected_fracs.size() != 0 && wait_cycles < 100000) begin
                    @(posedge i_clk);
                    wait_cycles++;
                end
                @(negedge i_clk);
            end
            rq.mode = $urandom_range(0, 3);
            rq.a_num = rand_word();
            rq.a_den = rand_word();
            rq.b_num = rand_word();
            rq.b_den = rand_word();
            send_request(rq);
        end
        i_req_valid <= 1'b0;
        stim_done = 1'b1;

        // Drain
        wait_cycles = 0;
        while (expected_fracs.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && expected_fracs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
